// ===== hw/rtl/poc_pkg.sv =====
// Shared constants and types of the pattern occurrence counter.
package poc_pkg;

  localparam int unsigned MaxPattern = 24;
  localparam int unsigned RegBytes   = 24;
  localparam int unsigned LenCap     = (MaxPattern < RegBytes) ? MaxPattern : RegBytes;
  localparam int unsigned CntW       = $clog2(LenCap + 1);
  localparam int unsigned IdxW       = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
  localparam int unsigned LenW       = 5;
  localparam int unsigned TotalW     = 16;
  localparam int unsigned PatW       = 8 * RegBytes;
  localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};

  typedef enum logic [1:0] {
    CfgPatLow  = 2'd0,
    CfgPatMid  = 2'd1,
    CfgPatHigh = 2'd2,
    CfgPatLen  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic advance;   // take the staged byte into the window
    logic name_end;  // staged byte closes the current name
  } win_ctrl_t;

endpackage

// ===== hw/rtl/pattern_occurrence_counter_top.sv =====
// Top level of the pattern occurrence counter: staging, counting and result register.
// A byte request is staged at the edge that accepts it, and a set-end result is
// loaded into the output register when the staged set-end byte is processed.
// Throughput: one byte per cycle; the only stall is a set-end byte that finds
// the result register still full and not being taken.
// Reset: asynchronous, active low; clears window, name count, total, flags and
// pattern registers (pattern length returns to one).
module pattern_occurrence_counter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  // text byte channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_name_i,
  input  logic        end_of_set_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] occurrence_total_o,
  output logic        total_saturated_o
);

  // Pattern registers
  logic [63:0]              pat_low_q, pat_mid_q, pat_high_q;
  logic [poc_pkg::LenW-1:0] pat_len_q;
  logic [poc_pkg::PatW-1:0] pattern;

  // Staging register for the accepted byte request
  logic       stg_valid_q;
  logic [7:0] stg_byte_q;
  logic       stg_eon_q, stg_eos_q;

  // Running count
  logic [poc_pkg::TotalW-1:0] total_q, total_d, total_upd;
  logic                       sat_q, sat_d, sat_upd;

  // Result register
  logic                       out_valid_q;
  logic [poc_pkg::TotalW-1:0] out_total_q;
  logic                       out_sat_q;

  logic               process;
  logic               match;
  poc_pkg::win_ctrl_t win_ctrl;

  // Configuration is always taken; the user must make writes arrive only while idle, the block does not enforce it.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_mid_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= poc_pkg::LenW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (poc_pkg::cfg_idx_e'(cfg_index_i))
        poc_pkg::CfgPatLow:  pat_low_q  <= cfg_data_i;
        poc_pkg::CfgPatMid:  pat_mid_q  <= cfg_data_i;
        poc_pkg::CfgPatHigh: pat_high_q <= cfg_data_i;
        poc_pkg::CfgPatLen:  pat_len_q  <= cfg_data_i[poc_pkg::LenW-1:0];
        default:             pat_len_q  <= pat_len_q;
      endcase
    end
  end

  // Byte 0 sits in the low word's bottom bits.
  assign pattern = poc_pkg::PatW'({pat_high_q, pat_mid_q, pat_low_q});

  // Advance the staged byte unless it closes a set and the result slot is
  // still held by an untaken result.
  assign process    = stg_valid_q && (!stg_eos_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !stg_valid_q || process;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      stg_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      stg_byte_q <= text_byte_i;
      stg_eon_q  <= end_of_name_i;
      stg_eos_q  <= end_of_set_i;
    end
  end

  assign win_ctrl.advance  = process;
  assign win_ctrl.name_end = stg_eon_q || stg_eos_q;

  poc_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (win_ctrl),
    .byte_i    (stg_byte_q),
    .pattern_i (pattern),
    .length_i  (pat_len_q),
    .match_o   (match)
  );

  // Count the match, holding at the ceiling and flagging the drop; a processed set end clears both.
  always_comb begin
    total_upd = total_q;
    sat_upd   = sat_q;
    if (match) begin
      if (total_q == poc_pkg::TotalMax) begin
        sat_upd = 1'b1;
      end else begin
        total_upd = total_q + poc_pkg::TotalW'(1);
      end
    end
    total_d = total_q;
    sat_d   = sat_q;
    if (process) begin
      total_d = stg_eos_q ? '0 : total_upd;
      sat_d   = stg_eos_q ? 1'b0 : sat_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      total_q <= total_d;
      sat_q   <= sat_d;
      if (process && stg_eos_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the set total, including the closing byte's own match.
  always_ff @(posedge clk_i) begin
    if (process && stg_eos_q) begin
      out_total_q <= total_upd;
      out_sat_q   <= sat_upd;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign occurrence_total_o = out_total_q;
  assign total_saturated_o  = out_sat_q;

  // A stalled input side only ever comes from a waiting set-end byte.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (stg_valid_q && stg_eos_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a blocked set-end byte");

  // A saturated result must report the ceiling.
  a_sat_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && total_saturated_o) |-> (occurrence_total_o == poc_pkg::TotalMax))
    else $error("saturated result below the ceiling");

  // A processed set-end byte leaves a result and a cleared count behind.
  a_set_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (process && stg_eos_q) |=> (out_valid_q && total_q == '0 && !sat_q))
    else $error("set end did not post a result and clear the count");

endmodule

// ===== hw/rtl/poc_window.sv =====
// Sliding byte window with bytes-in-name count and parallel pattern compare.
module poc_window (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  poc_pkg::win_ctrl_t       ctrl_i,
  input  logic [7:0]               byte_i,
  input  logic [poc_pkg::PatW-1:0] pattern_i,
  input  logic [poc_pkg::LenW-1:0] length_i,
  output logic                     match_o
);

  logic [7:0]              recent_q [poc_pkg::MaxPattern];
  logic [7:0]              win      [poc_pkg::MaxPattern];
  logic [poc_pkg::CntW-1:0] bin_q, bin_d, bin_inc;
  logic [poc_pkg::CntW-1:0] eff_len;

  // Clamp the length into one to the storage cap.
  always_comb begin
    if (length_i == '0) begin
      eff_len = poc_pkg::CntW'(1);
    end else if (32'(length_i) > poc_pkg::LenCap) begin
      eff_len = poc_pkg::CntW'(poc_pkg::LenCap);
    end else begin
      eff_len = poc_pkg::CntW'(length_i);
    end
  end

  // Window as it stands once the staged byte is in: newest at entry 0.
  always_comb begin
    win[0] = byte_i;
    for (int j = 1; j < poc_pkg::MaxPattern; j++) begin
      win[j] = recent_q[j-1];
    end
  end

  assign bin_inc = (32'(bin_q) < poc_pkg::LenCap) ? bin_q + poc_pkg::CntW'(1) : bin_q;

  // Pattern byte k lines up with the window entry len-1-k.
  always_comb begin
    logic [poc_pkg::IdxW-1:0] idx;
    logic                     ok;
    ok = (bin_inc >= eff_len);
    for (int k = 0; k < poc_pkg::LenCap; k++) begin
      idx = poc_pkg::IdxW'(eff_len - poc_pkg::CntW'(k) - poc_pkg::CntW'(1));
      if (poc_pkg::CntW'(k) < eff_len) begin
        if (win[idx] != pattern_i[8*k +: 8]) begin
          ok = 1'b0;
        end
      end
    end
    match_o = ok;
  end

  always_comb begin
    bin_d = bin_q;
    if (ctrl_i.advance) begin
      bin_d = ctrl_i.name_end ? '0 : bin_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_q <= '0;
      for (int j = 0; j < poc_pkg::MaxPattern; j++) begin
        recent_q[j] <= '0;
      end
    end else begin
      bin_q <= bin_d;
      if (ctrl_i.advance) begin
        for (int j = 0; j < poc_pkg::MaxPattern; j++) begin
          recent_q[j] <= win[j];
        end
      end
    end
  end

endmodule

// ===== sim/tb_pattern_occurrence_counter_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the pattern occurrence counter top level.
module tb_pattern_occurrence_counter_top;

  localparam int unsigned HalfPeriod   = 5;
  localparam int unsigned ResetCycles  = 9;
  localparam int unsigned DrainCycles  = 4;
  localparam int unsigned CycleLimit   = 1_000_000;
  localparam int unsigned RxHoldCycles = 300;
  localparam int unsigned PhaseBytes   = 75;
  localparam int unsigned SteadyBytes  = 80;

  typedef struct packed {
    logic [poc_pkg::TotalW-1:0] total;
    logic                       saturated;
  } set_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i   = poc_pkg::CfgPatLow;
  logic [63:0] cfg_data_i    = '0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [7:0]  text_byte_i   = '0;
  logic        end_of_name_i = 1'b0;
  logic        end_of_set_i  = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [15:0] occurrence_total_o;
  logic        total_saturated_o;

  pattern_occurrence_counter_top u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .text_byte_i       (text_byte_i),
    .end_of_name_i     (end_of_name_i),
    .end_of_set_i      (end_of_set_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .occurrence_total_o(occurrence_total_o),
    .total_saturated_o (total_saturated_o)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // Predicted block state: byte window (newest at entry 0), name fill, set total.
  logic [7:0]                 recent_q [poc_pkg::MaxPattern];
  int unsigned                name_fill;
  logic [poc_pkg::TotalW-1:0] set_count;
  logic                       set_sat;
  logic [63:0]                pat_word [3];
  logic [poc_pkg::LenW-1:0]   pat_len;
  set_result_t                totals_due [$];

  // Run bookkeeping
  int unsigned faults          = 0;
  int unsigned cycles          = 0;
  int unsigned bytes_sent      = 0;
  int unsigned sets_seen       = 0;
  int unsigned results_checked = 0;
  int unsigned settings_loaded = 0;

  // Traffic shaping shared by the sender, the receiver and the tests
  bit          steady       = 1'b0;
  int unsigned rx_hold_req  = 0;
  int unsigned rx_hold_seen = 0;
  int unsigned rx_hold_left = 0;

  task automatic report_fault(string msg);
    faults++;
    $display("%0t ns mismatch: %s", $time, msg);
  endtask

  function automatic int unsigned live_length();
    int unsigned len;
    len = pat_len;
    if (len == 0) len = 1;
    if (len > poc_pkg::LenCap) len = poc_pkg::LenCap;
    return len;
  endfunction

  function automatic logic [7:0] pat_byte(int unsigned k);
    return pat_word[k / 8][(k % 8) * 8 +: 8];
  endfunction

  task automatic reset_model();
    foreach (recent_q[i]) recent_q[i] = '0;
    foreach (pat_word[i]) pat_word[i] = '0;
    pat_len   = poc_pkg::LenW'(1);
    name_fill = 0;
    set_count = '0;
    set_sat   = 1'b0;
  endtask

  // Advance the predicted state by one accepted byte request; queue the set
  // total when the byte closes the set.
  task automatic predict_byte(logic [7:0] b, logic eon, logic eos);
    int unsigned len;
    bit          hit;
    len = live_length();
    for (int i = poc_pkg::MaxPattern - 1; i > 0; i--) recent_q[i] = recent_q[i - 1];
    recent_q[0] = b;
    if (name_fill < poc_pkg::LenCap) name_fill++;
    hit = (name_fill >= len);
    for (int k = 0; k < len; k++) begin
      if (recent_q[len - 1 - k] != pat_byte(k)) hit = 1'b0;
    end
    if (hit) begin
      if (set_count == poc_pkg::TotalMax) set_sat = 1'b1;
      else set_count++;
    end
    if (eon || eos) name_fill = 0;
    if (eos) begin
      totals_due.push_back(set_result_t'{total: set_count, saturated: set_sat});
      set_count = '0;
      set_sat   = 1'b0;
      sets_seen++;
    end
  endtask

  // Offer one byte request; hold valid and payload until it is taken.
  task automatic send_byte(logic [7:0] b, logic eon, logic eos);
    if (!steady && $urandom_range(99) < 9) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    text_byte_i   <= b;
    end_of_name_i <= eon;
    end_of_set_i  <= eos;
    do @(posedge clk_i); while (!in_ready_o);
    predict_byte(b, eon, eos);
    bytes_sent++;
  endtask

  // Drop valid, wait for every outstanding total, then let the pipeline empty.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (totals_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write all four pattern registers in index order; only call when idle.
  task automatic load_pattern(logic [63:0] lo, logic [63:0] mid, logic [63:0] hi,
                              logic [63:0] len_word);
    poc_pkg::cfg_idx_e idx;
    logic [63:0]       word;
    idx = idx.first();
    repeat (idx.num()) begin
      case (idx)
        poc_pkg::CfgPatLow:  word = lo;
        poc_pkg::CfgPatMid:  word = mid;
        poc_pkg::CfgPatHigh: word = hi;
        default:             word = len_word;
      endcase
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= word;
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx)
        poc_pkg::CfgPatLow:  pat_word[0] = word;
        poc_pkg::CfgPatMid:  pat_word[1] = word;
        poc_pkg::CfgPatHigh: pat_word[2] = word;
        poc_pkg::CfgPatLen:  pat_len     = word[poc_pkg::LenW-1:0];
        default:             ;
      endcase
      idx = idx.next();
    end
    cfg_valid_i <= 1'b0;
    settings_loaded++;
    repeat (2) @(posedge clk_i);
  endtask

  // One name built from pattern copies, partial copies and filler; the last
  // byte closes the name, or the set when asked.
  task automatic send_name(logic [7:0] a0, logic [7:0] a1, bit last_in_set);
    logic [7:0]  name_q [$];
    int unsigned len;
    int unsigned pick;
    int unsigned cut;
    bit          stop;
    bit          tail;
    len  = live_length();
    stop = 1'b0;
    while (!stop) begin
      pick = $urandom_range(11);
      if (pick <= 3) begin
        cut = (pick == 3) ? $urandom_range(1, len) : len;
        for (int k = 0; k < cut; k++) name_q.push_back(pat_byte(k));
      end else if (pick <= 6) begin
        name_q.push_back($urandom_range(1) ? a1 : a0);
      end else if (pick <= 8) begin
        name_q.push_back(8'($urandom_range(255)));
      end else begin
        stop = (name_q.size() != 0);
      end
      if (name_q.size() >= 16) stop = 1'b1;
    end
    foreach (name_q[n]) begin
      tail = (n == name_q.size() - 1);
      if (tail && last_in_set) send_byte(name_q[n], 1'($urandom_range(1)), 1'b1);
      else send_byte(name_q[n], tail, 1'b0);
    end
  endtask

  // Result checker: compare each taken total with the oldest prediction.
  always @(posedge clk_i) begin
    set_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (totals_due.size() == 0) begin
        report_fault($sformatf("unexpected total %0d (sat %0b)",
                               occurrence_total_o, total_saturated_o));
      end else begin
        want = totals_due.pop_front();
        if (occurrence_total_o !== want.total)
          report_fault($sformatf("total %0d, predicted %0d", occurrence_total_o, want.total));
        if (total_saturated_o !== want.saturated)
          report_fault($sformatf("saturated %0b, predicted %0b",
                                 total_saturated_o, want.saturated));
        results_checked++;
      end
    end
  end

  // Receiver: random stalls, a steady mode, and a long hold-off on request.
  always @(posedge clk_i) begin
    if (rx_hold_req != rx_hold_seen) begin
      rx_hold_seen = rx_hold_req;
      rx_hold_left = RxHoldCycles;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready_i <= 1'b0;
    end else if (steady) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= 9);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Reset pattern is a single zero byte: zero bytes count, others do not.
  task automatic test_reset_pattern();
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    drain_results();
  endtask

  // Overlaps, no match across a name end, and end of set alone closing a name.
  task automatic test_name_boundaries();
    load_pattern(64'h0000_0000_00FF_00FF, '0, '0, 64'hFFFF_FFFF_FFFF_FFE3);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    drain_results();
  endtask

  // A zero length behaves as one; upper bits of the length word are ignored.
  task automatic test_length_zero();
    load_pattern(64'hFFFF_FFFF_FFFF_FF61, '1, '1, 64'hFFFF_FFFF_FFFF_FFE0);
    send_byte(8'h61, 1'b0, 1'b0);
    send_byte(8'h61, 1'b1, 1'b0);
    send_byte(8'h62, 1'b0, 1'b0);
    send_byte(8'h61, 1'b0, 1'b1);
    drain_results();
  endtask

  // Back-to-back bytes with both sides always ready.
  task automatic test_steady_run();
    load_pattern(64'h41, '0, '0, 64'h1);
    steady <= 1'b1;
    for (int n = 1; n <= SteadyBytes; n++)
      send_byte(($urandom_range(3) == 0) ? 8'h42 : 8'h41, ($urandom_range(15) == 0),
                (n % 40 == 0));
    steady <= 1'b0;
    drain_results();
  endtask

  // Hold the receiver off while dense set ends fill the block and stall it.
  task automatic test_result_stall();
    load_pattern(64'h6261, '0, '0, 64'h2);
    rx_hold_req <= rx_hold_req + 1;
    for (int n = 0; n < 30; n++)
      send_byte($urandom_range(1) ? 8'h61 : 8'h62, 1'b0, (n % 3 == 2));
    drain_results();
  endtask

  // Random sets of names under a run of pattern settings, extremes first.
  task automatic test_random_sets();
    int unsigned lens [12];
    logic [7:0]  pb [poc_pkg::LenCap];
    logic [63:0] words [3];
    logic [63:0] len_word;
    logic [7:0]  a0;
    logic [7:0]  a1;
    int unsigned mode;
    int unsigned phase_start;
    int unsigned names;
    lens = '{1, 24, 0, 31, 25, 2, 3, 5, 8, 12, 17, 4};
    lens[11] = $urandom_range(31);
    for (int p = 0; p < 12; p++) begin
      a0   = 8'($urandom_range(255));
      a1   = 8'($urandom_range(255));
      mode = (p < 2) ? 3 + p : $urandom_range(2);
      foreach (pb[k]) begin
        case (mode)
          0:       pb[k] = 8'($urandom_range(255));
          1:       pb[k] = $urandom_range(1) ? a1 : a0;
          2:       pb[k] = a0;
          3:       pb[k] = 8'h00;
          default: pb[k] = 8'hFF;
        endcase
      end
      foreach (pb[k]) words[k / 8][(k % 8) * 8 +: 8] = pb[k];
      len_word = {$urandom(), $urandom()};
      len_word[poc_pkg::LenW-1:0] = poc_pkg::LenW'(lens[p]);
      load_pattern(words[0], words[1], words[2], len_word);
      if (mode >= 2) a0 = pb[0];
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PhaseBytes) begin
        if ($urandom_range(9) == 0) begin
          // noise: random bytes and flags, closed by a set end
          repeat ($urandom_range(1, 20))
            send_byte(8'($urandom_range(255)), ($urandom_range(5) == 0),
                      ($urandom_range(19) == 0));
          send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
        end else begin
          names = $urandom_range(1, 2);
          for (int n = 1; n <= names; n++) send_name(a0, a1, (n == names));
        end
      end
      drain_results();
    end
  endtask

  initial begin
    reset_model();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_pattern();
    test_name_boundaries();
    test_length_zero();
    test_steady_run();
    test_result_stall();
    test_random_sets();
    drain_results();
    $display("Sent %0d text bytes in %0d sets over %0d pattern settings; %0d totals checked.",
             bytes_sent, sets_seen, settings_loaded, results_checked);
    $display("Included reset pattern, name ends, length limits, steady run, long result stall.");
    if (faults == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
